// ===== hdl/fgws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgws_pkg - shared types and constants of the font glyph width scanner
// Table geometry, field codes, control states and the cell summary record.
// ----------------------------------------------------------------------------
package fgws_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [7:0] DARK_LIMIT = 8'd85;
   localparam logic [7:0] FIRST_CHAR = 8'd32;
   // entry of lowercase 't', whose width the space entry copies
   localparam logic [TABLE_AW-1:0] T_ENTRY = TABLE_AW'(8'd116 - 8'd32);

   localparam logic [1:0] FN_BEGIN = 2'd0;
   localparam logic [1:0] FN_PIXEL = 2'd1;
   localparam logic [1:0] FN_TEXT  = 2'd2;

   localparam logic KIND_GLYPH = 1'b0;
   localparam logic KIND_TEXT  = 1'b1;

   localparam logic [1:0] REG_CELL_SIZE     = 2'd0;
   localparam logic [1:0] REG_CELLS_PER_ROW = 2'd1;
   localparam logic [1:0] REG_CHAR_GAP      = 2'd2;

   localparam logic [6:0] CELL_SIZE_RST     = 7'd16;
   localparam logic [6:0] CELLS_PER_ROW_RST = 7'd16;
   localparam logic [7:0] CHAR_GAP_RST      = 8'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TEXT,
      ST_SPACE_RD,
      ST_SPACE_WR
   } ctl_state_type;

   typedef struct packed {
      logic                cell_end;
      logic                last_cell;
      logic                empty_grid;
      logic [TABLE_AW-1:0] index;
      logic [14:0]         glyph_x;
      logic [13:0]         glyph_y;
      logic [7:0]          width;
   } cell_info_type;

endpackage

// ===== hdl/fgws_width_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgws_width_store - glyph width memory with per-entry written flags
// One write and one registered read per cycle; flags clear on reset.
// ----------------------------------------------------------------------------
module fgws_width_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [fgws_pkg::TABLE_AW-1:0] wr_addr,
   input  logic [7:0]                   wr_data,
   input  logic [fgws_pkg::TABLE_AW-1:0] rd_addr,
   output logic [7:0]                   rd_data,
   output logic                         rd_written
);

   logic [7:0] mem [fgws_pkg::TABLE_DEPTH];
   logic [fgws_pkg::TABLE_DEPTH-1:0] written_ff;
   logic [7:0] rd_data_ff;
   logic       rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign rd_written = rd_written_ff;

endmodule

// ===== hdl/fgws_cell_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgws_cell_scan - pixel walker and glyph box tracker
// Steps through cells of the grid and summarizes each finished cell.
// ----------------------------------------------------------------------------
module fgws_cell_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    begin_scan,
   input  logic                    pixel_strobe,
   input  logic [7:0]              red_value,
   input  logic [6:0]              cell_size,
   input  logic [6:0]              cells_per_row,
   output fgws_pkg::cell_info_type cell_info
);

   logic                       active_ff, active_in;
   logic [fgws_pkg::CNT_W-1:0] count_ff, count_in;
   logic [6:0]                 column_ff, column_in;
   logic [13:0]                origin_x_ff, origin_x_in;
   logic [13:0]                origin_y_ff, origin_y_in;
   logic [6:0]                 pixel_x_ff, pixel_x_in;
   logic [6:0]                 pixel_y_ff, pixel_y_in;
   logic signed [8:0]          least_x_ff, least_x_in;
   logic [6:0]                 most_x_ff, most_x_in;
   logic [6:0]                 most_y_ff, most_y_in;

   logic                       dark;
   logic [6:0]                 most_x_n, most_y_n;
   logic signed [8:0]          least_n;
   logic                       x_wrap, cell_done, has_box, last_cell;
   logic [13:0]                total_sq;
   logic [fgws_pkg::CNT_W-1:0] total_cells;
   logic signed [9:0]          box_width;
   logic [14:0]                box_x;
   logic [6:0]                 column_n;
   logic signed [8:0]          least_open;

   always_comb begin
      dark     = red_value < fgws_pkg::DARK_LIMIT;
      most_x_n = (dark && pixel_x_ff > most_x_ff) ? pixel_x_ff : most_x_ff;
      most_y_n = (dark && pixel_y_ff > most_y_ff) ? pixel_y_ff : most_y_ff;
      least_n  = (dark && $signed({2'b00, pixel_x_ff}) < least_x_ff) ?
                 $signed({2'b00, pixel_x_ff}) - 9'sd1 : least_x_ff;

      x_wrap    = ({1'b0, pixel_x_ff} + 8'd1) >= {1'b0, cell_size};
      cell_done = x_wrap && (({1'b0, pixel_y_ff} + 8'd1) >= {1'b0, cell_size});

      total_sq    = cells_per_row * cells_per_row;
      total_cells = (total_sq > 14'(fgws_pkg::TABLE_DEPTH)) ?
                    fgws_pkg::CNT_W'(fgws_pkg::TABLE_DEPTH) :
                    fgws_pkg::CNT_W'(total_sq);
      last_cell   = ({1'b0, count_ff} + 1'b1) >= {1'b0, total_cells};

      // box spans from one left of the leftmost dark pixel, plus margin
      has_box   = (most_x_n != 7'd0) && (most_y_n != 7'd0);
      box_width = $signed({3'b000, most_x_n}) - 10'(least_n) + 10'sd3;
      box_x     = {1'b0, origin_x_ff} + 15'(least_n) - 15'd1;

      column_n   = column_ff + 7'd1;
      least_open = $signed({2'b00, cell_size}) + 9'sd1;
   end

   always_comb begin
      active_in   = active_ff;
      count_in    = count_ff;
      column_in   = column_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      pixel_x_in  = pixel_x_ff;
      pixel_y_in  = pixel_y_ff;
      least_x_in  = least_x_ff;
      most_x_in   = most_x_ff;
      most_y_in   = most_y_ff;
      if (begin_scan) begin
         active_in   = cells_per_row != 7'd0;
         count_in    = '0;
         column_in   = '0;
         origin_x_in = '0;
         origin_y_in = '0;
         pixel_x_in  = '0;
         pixel_y_in  = '0;
         least_x_in  = least_open;
         most_x_in   = '0;
         most_y_in   = '0;
      end else if (pixel_strobe && active_ff) begin
         if (!cell_done) begin
            least_x_in = least_n;
            most_x_in  = most_x_n;
            most_y_in  = most_y_n;
            if (x_wrap) begin
               pixel_x_in = '0;
               pixel_y_in = pixel_y_ff + 7'd1;
            end else begin
               pixel_x_in = pixel_x_ff + 7'd1;
            end
         end else begin
            count_in = count_ff + 1'b1;
            if (last_cell) begin
               active_in = 1'b0;
            end else begin
               // open the next cell, wrap to a new grid row when full
               pixel_x_in = '0;
               pixel_y_in = '0;
               least_x_in = least_open;
               most_x_in  = '0;
               most_y_in  = '0;
               if (column_n >= cells_per_row) begin
                  column_in   = '0;
                  origin_x_in = '0;
                  origin_y_in = origin_y_ff + {7'd0, cell_size};
               end else begin
                  column_in   = column_n;
                  origin_x_in = origin_x_ff + {7'd0, cell_size};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         count_ff    <= '0;
         column_ff   <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         pixel_x_ff  <= '0;
         pixel_y_ff  <= '0;
         least_x_ff  <= $signed({2'b00, fgws_pkg::CELL_SIZE_RST}) + 9'sd1;
         most_x_ff   <= '0;
         most_y_ff   <= '0;
      end else begin
         active_ff   <= active_in;
         count_ff    <= count_in;
         column_ff   <= column_in;
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         pixel_x_ff  <= pixel_x_in;
         pixel_y_ff  <= pixel_y_in;
         least_x_ff  <= least_x_in;
         most_x_ff   <= most_x_in;
         most_y_ff   <= most_y_in;
      end
   end

   always_comb begin
      cell_info.cell_end   = pixel_strobe && active_ff && cell_done && !begin_scan;
      cell_info.last_cell  = last_cell;
      cell_info.empty_grid = cells_per_row == 7'd0;
      cell_info.index      = count_ff[fgws_pkg::TABLE_AW-1:0];
      cell_info.glyph_x    = has_box ? box_x : {1'b0, origin_x_ff};
      cell_info.glyph_y    = origin_y_ff;
      cell_info.width      = has_box ? box_width[7:0] : {1'b0, cell_size};
   end

endmodule

// ===== hdl/font_glyph_width_scanner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// font_glyph_width_scanner_core - proportional font width table and text meter
// Scans a glyph grid into a width table, then sums string widths.
// ----------------------------------------------------------------------------
//
//  channel  | direction | beat contents
//  ---------+-----------+------------------------------------------------------
//  req_     | in        | tuser func, tdata red/text byte/present, tlast last byte
//  rsp_     | out       | tuser kind, tdata glyph box or text length, tlast done
//  csr_     | in        | register index and 8-bit write data
//
// Begin, pixel and non-printable text beats are handled in the idle state; a
// character in 32..127 also passes through the text state, as its width comes
// from the registered width memory. The last cell of a scan, or a begin on an
// empty grid, runs the space-entry copy (read entry of 't', then write entry 0).
// Reset is synchronous and clears control state and the written flags, so no
// clearing pass runs. A full result register that is not taken stalls req_.
//
module font_glyph_width_scanner_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // red_value[7:0], text_byte[15:8],
                                   // byte_present[16], zero[23:17]
   input  logic [1:0]  req_tuser,  // func[1:0]
   input  logic        req_tlast,  // last_byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // cell_index[7:0], glyph_x[22:8],
                                   // glyph_y[36:23], glyph_width[44:37],
                                   // text_length[60:45], zero[63:61]
   output logic        rsp_tuser,  // kind
   output logic        rsp_tlast,  // scan_done
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   // ---------------------------------------------------------------- config
   logic [6:0] cell_size_ff;
   logic [6:0] cells_per_row_ff;
   logic [7:0] char_gap_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff     <= fgws_pkg::CELL_SIZE_RST;
         cells_per_row_ff <= fgws_pkg::CELLS_PER_ROW_RST;
         char_gap_ff      <= fgws_pkg::CHAR_GAP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fgws_pkg::REG_CELL_SIZE:     cell_size_ff     <= csr_data[6:0];
            fgws_pkg::REG_CELLS_PER_ROW: cells_per_row_ff <= csr_data[6:0];
            fgws_pkg::REG_CHAR_GAP:      char_gap_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------- request decode
   logic       req_accept;
   logic [7:0] req_red;
   logic [7:0] req_byte;
   logic       req_present;
   logic       is_begin, is_pixel, is_text;
   logic       text_in_range;
   logic       rsp_free;

   assign req_accept  = req_tvalid && req_tready;
   assign req_red     = req_tdata[7:0];
   assign req_byte    = req_tdata[15:8];
   assign req_present = req_tdata[16];
   assign is_begin    = req_accept && (req_tuser == fgws_pkg::FN_BEGIN);
   assign is_pixel    = req_accept && (req_tuser == fgws_pkg::FN_PIXEL);
   assign is_text     = req_accept && (req_tuser == fgws_pkg::FN_TEXT);
   // printable ASCII: 32..127
   assign text_in_range = (req_byte >= fgws_pkg::FIRST_CHAR) && !req_byte[7];

   // ------------------------------------------------------------ cell scan
   fgws_pkg::cell_info_type cell_info;

   fgws_cell_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .begin_scan    (is_begin),
      .pixel_strobe  (is_pixel),
      .red_value     (req_red),
      .cell_size     (cell_size_ff),
      .cells_per_row (cells_per_row_ff),
      .cell_info     (cell_info)
   );

   // ---------------------------------------------------------- width memory
   logic                          mem_wr_en;
   logic [fgws_pkg::TABLE_AW-1:0] mem_wr_addr;
   logic [7:0]                    mem_wr_data;
   logic [fgws_pkg::TABLE_AW-1:0] mem_rd_addr;
   logic [7:0]                    mem_rd_data;
   logic                          mem_rd_written;
   logic [7:0]                    looked_up_width;

   fgws_width_store u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_addr    (mem_rd_addr),
      .rd_data    (mem_rd_data),
      .rd_written (mem_rd_written)
   );

   // an entry never written reads as the grid cell size
   assign looked_up_width = mem_rd_written ? mem_rd_data : {1'b0, cell_size_ff};

   // ------------------------------------------------------------- sequencer
   fgws_pkg::ctl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fgws_pkg::ST_IDLE: begin
            if (is_begin && cell_info.empty_grid) begin
               state_in = fgws_pkg::ST_SPACE_RD;
            end else if (cell_info.cell_end && cell_info.last_cell) begin
               state_in = fgws_pkg::ST_SPACE_RD;
            end else if (is_text && req_present && text_in_range) begin
               state_in = fgws_pkg::ST_TEXT;
            end
         end
         fgws_pkg::ST_TEXT:     state_in = fgws_pkg::ST_IDLE;
         fgws_pkg::ST_SPACE_RD: state_in = fgws_pkg::ST_SPACE_WR;
         fgws_pkg::ST_SPACE_WR: state_in = fgws_pkg::ST_IDLE;
         default:               state_in = fgws_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = cell_info.index;
      mem_wr_data = cell_info.width;
      mem_rd_addr = fgws_pkg::TABLE_AW'(req_byte[6:0] - fgws_pkg::FIRST_CHAR[6:0]);
      case (state_ff)
         fgws_pkg::ST_IDLE: begin
            req_tready = rsp_free;
            mem_wr_en  = cell_info.cell_end;
         end
         fgws_pkg::ST_TEXT: ;
         fgws_pkg::ST_SPACE_RD: begin
            mem_rd_addr = fgws_pkg::T_ENTRY;
         end
         fgws_pkg::ST_SPACE_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = looked_up_width;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fgws_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------- text meter
   logic [15:0] length_sum_ff, length_sum_in;
   logic        add_gap_ff;
   logic        last_char_ff;
   logic [15:0] gap_term;
   logic [15:0] sum_with_char;
   logic        text_emit_now;
   logic        text_emit_late;

   assign gap_term      = add_gap_ff ? {{8{char_gap_ff[7]}}, char_gap_ff} : 16'd0;
   assign sum_with_char = length_sum_ff + {8'd0, looked_up_width} + gap_term;
   // empty string, or a last byte outside the printable range, reports at once
   assign text_emit_now  = is_text && !(req_present && text_in_range) &&
                           (!req_present || req_tlast);
   assign text_emit_late = (state_ff == fgws_pkg::ST_TEXT) && last_char_ff;

   always_comb begin
      length_sum_in = length_sum_ff;
      if (text_emit_now) begin
         length_sum_in = '0;
      end else if (state_ff == fgws_pkg::ST_TEXT) begin
         length_sum_in = last_char_ff ? 16'd0 : sum_with_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_sum_ff <= '0;
      end else begin
         length_sum_ff <= length_sum_in;
      end
   end

   // hold the per-character flags for the lookup cycle
   always_ff @(posedge clock) begin
      if (is_text) begin
         add_gap_ff   <= req_byte != fgws_pkg::FIRST_CHAR;
         last_char_ff <= req_tlast;
      end
   end

   // -------------------------------------------------------- result register
   logic        rsp_valid_ff;
   logic        rsp_kind_ff;
   logic        rsp_done_ff;
   logic [63:0] rsp_data_ff;
   logic        rsp_load;

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = cell_info.cell_end || text_emit_now || text_emit_late;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_info.cell_end) begin
         rsp_kind_ff <= fgws_pkg::KIND_GLYPH;
         rsp_done_ff <= cell_info.last_cell;
         rsp_data_ff <= {3'd0, 16'd0, cell_info.width, cell_info.glyph_y,
                         cell_info.glyph_x, 8'(cell_info.index)};
      end else if (text_emit_now) begin
         rsp_kind_ff <= fgws_pkg::KIND_TEXT;
         rsp_done_ff <= 1'b0;
         rsp_data_ff <= {3'd0, length_sum_ff, 45'd0};
      end else if (text_emit_late) begin
         rsp_kind_ff <= fgws_pkg::KIND_TEXT;
         rsp_done_ff <= 1'b0;
         rsp_data_ff <= {3'd0, sum_with_char, 45'd0};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_done_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------ assertions
   // the text lookup cycle relies on the result register having drained
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fgws_pkg::ST_TEXT) |-> !rsp_valid_ff)
      else $error("text lookup with result register still full");

   // the last cell of a scan must start the space copy
   assert property (@(posedge clock) disable iff (reset)
      (cell_info.cell_end && cell_info.last_cell) |=>
      (state_ff == fgws_pkg::ST_SPACE_RD))
      else $error("last cell did not start the space copy");

   // the space write always follows its read of the 't' entry
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fgws_pkg::ST_SPACE_WR) |->
      ($past(state_ff) == fgws_pkg::ST_SPACE_RD))
      else $error("space write without preceding read");

   // no request is taken, and outside the text state no result is loaded, while busy
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != fgws_pkg::ST_IDLE) |-> !req_accept && !rsp_load ||
      (state_ff == fgws_pkg::ST_TEXT))
      else $error("request or result while sequencer busy");

endmodule
